// ----- rtl/rsbk_pkg.sv -----
`timescale 1ns / 1ps

package rsbk_pkg;

    localparam int CAPACITY = 16;
    localparam int KEY_W    = 16;
    localparam int CRED_W   = 4;
    localparam int ARR_W    = 4;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = $clog2(CAPACITY);

    localparam int Q_DEPTH  = 2;
    localparam int Q_PTR_W  = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);

    // one classified record on its way from front to back
    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [CRED_W-1:0] credit;
        logic [ARR_W-1:0]  pos;
        logic              keep;
        logic              last;
    } rsbk_entry_t;

    typedef struct packed {
        logic        valid;
        rsbk_entry_t entry;
    } rsbk_push_t;

endpackage

// ----- rtl/rsbk_front.sv -----
`timescale 1ns / 1ps

module rsbk_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [rsbk_pkg::KEY_W-1:0]    course_key,
    input  logic [rsbk_pkg::CRED_W-1:0]   credit_value,
    input  logic                          is_last,
    input  logic                          q_full,
    output rsbk_pkg::rsbk_push_t          push
);

    logic [rsbk_pkg::CNT_W-1:0] count_reg;
    logic [rsbk_pkg::CNT_W-1:0] count_next;
    logic                       accept;
    logic                       keep;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign keep     = (count_reg < rsbk_pkg::CNT_W'(rsbk_pkg::CAPACITY));

    always_comb
    begin
        count_next = count_reg;
        if (accept)
        begin
            if (is_last)
                count_next = '0;
            else if (keep)
                count_next = count_reg + rsbk_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end

    always_comb
    begin
        push.valid        = accept;
        push.entry.key    = course_key;
        push.entry.credit = credit_value;
        push.entry.pos    = rsbk_pkg::ARR_W'(count_reg);
        push.entry.keep   = keep;
        push.entry.last   = is_last;
    end

endmodule

// ----- rtl/rsbk_queue.sv -----
`timescale 1ns / 1ps

module rsbk_queue
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  rsbk_pkg::rsbk_push_t  push,
    output logic                  full,
    output logic                  empty,
    input  logic                  pop,
    output rsbk_pkg::rsbk_entry_t head
);

    rsbk_pkg::rsbk_entry_t        mem_reg [rsbk_pkg::Q_DEPTH];
    logic [rsbk_pkg::Q_PTR_W-1:0] wr_ptr_reg;
    logic [rsbk_pkg::Q_PTR_W-1:0] rd_ptr_reg;
    logic [rsbk_pkg::Q_CNT_W-1:0] cnt_reg;
    logic [rsbk_pkg::Q_PTR_W-1:0] wr_ptr_next;
    logic [rsbk_pkg::Q_PTR_W-1:0] rd_ptr_next;
    logic [rsbk_pkg::Q_CNT_W-1:0] cnt_next;
    logic                         do_push;
    logic                         do_pop;

    localparam logic [rsbk_pkg::Q_PTR_W-1:0] PTR_LAST = rsbk_pkg::Q_PTR_W'(rsbk_pkg::Q_DEPTH - 1);

    assign full    = (cnt_reg == rsbk_pkg::Q_CNT_W'(rsbk_pkg::Q_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push.valid && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + rsbk_pkg::Q_PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + rsbk_pkg::Q_PTR_W'(1);
        if (do_push && !do_pop)
            cnt_next = cnt_reg + rsbk_pkg::Q_CNT_W'(1);
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - rsbk_pkg::Q_CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push.entry;
    end

`ifndef SYNTH
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= rsbk_pkg::Q_CNT_W'(rsbk_pkg::Q_DEPTH))
        else $error("queue count beyond depth");

    a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (cnt_reg == $past(cnt_reg) + rsbk_pkg::Q_CNT_W'(1)))
        else $error("queue count lost a push");

    a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with unequal pointers");
`endif

endmodule

// ----- rtl/rsbk_back.sv -----
`timescale 1ns / 1ps

module rsbk_back
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_empty,
    output logic                          q_pop,
    input  rsbk_pkg::rsbk_entry_t         q_head,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [rsbk_pkg::KEY_W-1:0]    sorted_key,
    output logic [rsbk_pkg::CRED_W-1:0]   sorted_credit,
    output logic [rsbk_pkg::ARR_W-1:0]    arrival_index,
    output logic                          end_of_run,
    output logic                          overflowed
);

    typedef enum logic [1:0]
    {
        ST_FILL = 2'b01,
        ST_EMIT = 2'b10
    } state_t;

    state_t                      state_reg;
    state_t                      state_next;
    logic [rsbk_pkg::CNT_W-1:0]  n_reg;
    logic [rsbk_pkg::CNT_W-1:0]  n_next;
    logic                        ovf_reg;
    logic                        ovf_next;
    logic [rsbk_pkg::IDX_W-1:0]  idx_reg;
    logic [rsbk_pkg::IDX_W-1:0]  idx_next;

    logic [rsbk_pkg::KEY_W-1:0]  key_reg    [rsbk_pkg::CAPACITY];
    logic [rsbk_pkg::CRED_W-1:0] credit_reg [rsbk_pkg::CAPACITY];
    logic [rsbk_pkg::ARR_W-1:0]  pos_reg    [rsbk_pkg::CAPACITY];

    logic                        ov_reg;
    logic                        ov_next;
    logic [rsbk_pkg::KEY_W-1:0]  ok_reg;
    logic [rsbk_pkg::CRED_W-1:0] oc_reg;
    logic [rsbk_pkg::ARR_W-1:0]  op_reg;
    logic                        oe_reg;
    logic                        oo_reg;

    logic [rsbk_pkg::CAPACITY-1:0] gt;
    logic                          insert_en;
    logic                          out_free;
    logic                          load;
    logic                          emit_last;

    assign out_free  = !ov_reg || !out_stall;
    assign q_pop     = (state_reg == ST_FILL) && !q_empty;
    assign insert_en = q_pop && q_head.keep;
    assign load      = (state_reg == ST_EMIT) && out_free;
    assign emit_last = (rsbk_pkg::CNT_W'(idx_reg) == n_reg - rsbk_pkg::CNT_W'(1));

    // strictly greater: equal keys stay ahead of the new record
    always_comb
    begin
        for (int i = 0; i < rsbk_pkg::CAPACITY; i++)
            gt[i] = (rsbk_pkg::CNT_W'(i) < n_reg) && (key_reg[i] > q_head.key);
    end

    for (genvar g = 0; g < rsbk_pkg::CAPACITY; g++)
    begin : g_cell
        logic shift_in;
        logic place;

        if (g == 0)
        begin : g_first
            assign shift_in = 1'b0;
        end
        else
        begin : g_rest
            assign shift_in = gt[g-1];
        end

        assign place = !shift_in && (gt[g] || (rsbk_pkg::CNT_W'(g) == n_reg));

        always_ff @(posedge clk)
        begin
            if (insert_en)
            begin
                if (shift_in)
                begin
                    key_reg[g]    <= key_reg[(g > 0) ? g - 1 : 0];
                    credit_reg[g] <= credit_reg[(g > 0) ? g - 1 : 0];
                    pos_reg[g]    <= pos_reg[(g > 0) ? g - 1 : 0];
                end
                else if (place)
                begin
                    key_reg[g]    <= q_head.key;
                    credit_reg[g] <= q_head.credit;
                    pos_reg[g]    <= q_head.pos;
                end
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        ovf_next   = ovf_reg;
        idx_next   = idx_reg;
        ov_next    = ov_reg;
        if (ov_reg && !out_stall)
            ov_next = 1'b0;
        case (state_reg)
            ST_FILL:
            begin
                if (q_pop)
                begin
                    if (q_head.keep)
                        n_next = n_reg + rsbk_pkg::CNT_W'(1);
                    else
                        ovf_next = 1'b1;
                    if (q_head.last)
                    begin
                        state_next = ST_EMIT;
                        idx_next   = '0;
                    end
                end
            end
            ST_EMIT:
            begin
                if (load)
                begin
                    ov_next = 1'b1;
                    if (emit_last)
                    begin
                        state_next = ST_FILL;
                        n_next     = '0;
                        ovf_next   = 1'b0;
                    end
                    else
                    begin
                        idx_next = idx_reg + rsbk_pkg::IDX_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_FILL;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_FILL;
            n_reg     <= '0;
            ovf_reg   <= 1'b0;
            idx_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg     <= n_next;
            ovf_reg   <= ovf_next;
            idx_reg   <= idx_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ok_reg <= key_reg[idx_reg];
            oc_reg <= credit_reg[idx_reg];
            op_reg <= pos_reg[idx_reg];
            oe_reg <= emit_last;
            oo_reg <= ovf_reg;
        end
    end

    assign out_valid     = ov_reg;
    assign sorted_key    = ok_reg;
    assign sorted_credit = oc_reg;
    assign arrival_index = op_reg;
    assign end_of_run    = oe_reg;
    assign overflowed    = oo_reg;

`ifndef SYNTH
    a_n_bound: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= rsbk_pkg::CNT_W'(rsbk_pkg::CAPACITY))
        else $error("record count beyond capacity");

    a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (n_reg != '0))
        else $error("emitting an empty set");

    a_run_close: assert property (@(posedge clk) disable iff (!rst_n)
        (load && emit_last) |=> ((state_reg == ST_FILL) && (n_reg == '0) && !ovf_reg))
        else $error("set not cleared after final transaction");

    a_keep_room: assert property (@(posedge clk) disable iff (!rst_n)
        insert_en |-> (n_reg < rsbk_pkg::CNT_W'(rsbk_pkg::CAPACITY)))
        else $error("insert into full cells");
`endif

endmodule

// ----- rtl/record_sort_by_key_unit.sv -----
`timescale 1ns / 1ps
// Intake: one record per cycle into a two-entry queue until it is full; the sort cells insert one
// record per cycle while filling. Emission: one result per cycle from the sorted cells while out_stall
// is low, one result for each kept record of a set. After the is_last record, the set passes the queue
// entry, the switch to emit and the output register; while a set is emitted, intake stalls once the
// two queue entries are taken.
// Reset (rst_n, async, active low) clears counts, flags, queue and handshake state.

module record_sort_by_key_unit
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [rsbk_pkg::KEY_W-1:0]    course_key,
    input  logic [rsbk_pkg::CRED_W-1:0]   credit_value,
    input  logic                          is_last,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [rsbk_pkg::KEY_W-1:0]    sorted_key,
    output logic [rsbk_pkg::CRED_W-1:0]   sorted_credit,
    output logic [rsbk_pkg::ARR_W-1:0]    arrival_index,
    output logic                          end_of_run,
    output logic                          overflowed
);

    rsbk_pkg::rsbk_push_t  push;
    rsbk_pkg::rsbk_entry_t q_head;
    logic                  q_full;
    logic                  q_empty;
    logic                  q_pop;

    rsbk_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .course_key   (course_key),
        .credit_value (credit_value),
        .is_last      (is_last),
        .q_full       (q_full),
        .push         (push)
    );

    rsbk_queue u_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (q_full),
        .empty (q_empty),
        .pop   (q_pop),
        .head  (q_head)
    );

    rsbk_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_pop         (q_pop),
        .q_head        (q_head),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .sorted_key    (sorted_key),
        .sorted_credit (sorted_credit),
        .arrival_index (arrival_index),
        .end_of_run    (end_of_run),
        .overflowed    (overflowed)
    );

endmodule

// ----- dv/record_sort_checker.sv -----
`timescale 1ns / 1ps

module record_sort_checker
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_stall,
    input  logic [rsbk_pkg::KEY_W-1:0]   course_key,
    input  logic [rsbk_pkg::CRED_W-1:0]  credit_value,
    input  logic                         is_last,
    input  logic                         out_valid,
    input  logic                         out_stall,
    input  logic [rsbk_pkg::KEY_W-1:0]   sorted_key,
    input  logic [rsbk_pkg::CRED_W-1:0]  sorted_credit,
    input  logic [rsbk_pkg::ARR_W-1:0]   arrival_index,
    input  logic                         end_of_run,
    input  logic                         overflowed,
    output int                           fail_count,
    output int                           pending,
    output int                           results_seen
);

    typedef struct packed {
        logic [rsbk_pkg::KEY_W-1:0]  key;
        logic [rsbk_pkg::CRED_W-1:0] credit;
        logic [rsbk_pkg::ARR_W-1:0]  pos;
        logic                        eor;
        logic                        ovf;
    } sorted_rec_t;

    logic [rsbk_pkg::KEY_W-1:0]  held_key  [rsbk_pkg::CAPACITY];
    logic [rsbk_pkg::CRED_W-1:0] held_cred [rsbk_pkg::CAPACITY];
    int                          held_count;
    logic                        held_ovf;
    sorted_rec_t                 sorted_q[$];
    sorted_rec_t                 want;

    initial
    begin
        fail_count   = 0;
        pending      = 0;
        results_seen = 0;
        held_count   = 0;
        held_ovf     = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        fail_count++;
    endtask

    // stable insertion sort of the held set, queued as expected output
    task automatic release_sorted_set();
        sorted_rec_t recs [rsbk_pkg::CAPACITY];
        sorted_rec_t tmp;
        int          j;
        for (int i = 0; i < held_count; i++)
        begin
            recs[i] = '{held_key[i], held_cred[i], rsbk_pkg::ARR_W'(i), 1'b0, held_ovf};
        end
        for (int i = 1; i < held_count; i++)
        begin
            tmp = recs[i];
            j   = i;
            while (j > 0 && recs[j-1].key > tmp.key)
            begin
                recs[j] = recs[j-1];
                j--;
            end
            recs[j] = tmp;
        end
        for (int i = 0; i < held_count; i++)
        begin
            recs[i].eor = (i == held_count - 1);
            sorted_q.push_back(recs[i]);
        end
        held_count = 0;
        held_ovf   = 1'b0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sorted_q.delete();
            held_count = 0;
            held_ovf   = 1'b0;
            pending   <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (sorted_q.size() == 0)
                begin
                    report_mismatch($sformatf("result with none expected, key %h", sorted_key));
                end
                else
                begin
                    want = sorted_q.pop_front();
                    if (sorted_key !== want.key)
                        report_mismatch($sformatf("sorted_key %h, want %h",
                                                  sorted_key, want.key));
                    if (sorted_credit !== want.credit)
                        report_mismatch($sformatf("sorted_credit %h, want %h (key %h)",
                                                  sorted_credit, want.credit, want.key));
                    if (arrival_index !== want.pos)
                        report_mismatch($sformatf("arrival_index %0d, want %0d (key %h)",
                                                  arrival_index, want.pos, want.key));
                    if (end_of_run !== want.eor)
                        report_mismatch($sformatf("end_of_run %b, want %b (key %h)",
                                                  end_of_run, want.eor, want.key));
                    if (overflowed !== want.ovf)
                        report_mismatch($sformatf("overflowed %b, want %b (key %h)",
                                                  overflowed, want.ovf, want.key));
                end
            end
            if (in_valid && !in_stall)
            begin
                if (held_count < rsbk_pkg::CAPACITY)
                begin
                    held_key[held_count]  = course_key;
                    held_cred[held_count] = credit_value;
                    held_count++;
                end
                else
                begin
                    held_ovf = 1'b1;
                end
                if (is_last)
                    release_sorted_set();
            end
            pending <= sorted_q.size();
        end
    end

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

module tb;

    localparam int CYCLE_LIMIT   = 300000;
    localparam int TOTAL_RECORDS = 225;

    typedef enum int {STALL_NONE, STALL_RANDOM, STALL_HEAVY, STALL_TOGGLE} stall_mode_t;
    typedef enum int {MIX_WIDE, MIX_TIES, MIX_EDGES} key_mix_t;

    logic                        clk          = 1'b0;
    logic                        rst_n        = 1'b0;
    logic                        in_valid     = 1'b0;
    logic [rsbk_pkg::KEY_W-1:0]  course_key   = '0;
    logic [rsbk_pkg::CRED_W-1:0] credit_value = '0;
    logic                        is_last      = 1'b0;
    logic                        out_stall    = 1'b0;

    logic                        in_stall;
    logic                        out_valid;
    logic [rsbk_pkg::KEY_W-1:0]  sorted_key;
    logic [rsbk_pkg::CRED_W-1:0] sorted_credit;
    logic [rsbk_pkg::ARR_W-1:0]  arrival_index;
    logic                        end_of_run;
    logic                        overflowed;

    int          fail_count;
    int          pending;
    int          results_seen;
    int          cycles        = 0;
    int          burst_left    = 0;
    int          sets_sent     = 0;
    int          records_sent  = 0;
    int          overflow_sets = 0;
    int          stall_left    = 0;
    stall_mode_t stall_mode    = STALL_NONE;

    always #5 clk = ~clk;

    record_sort_by_key_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .course_key    (course_key),
        .credit_value  (credit_value),
        .is_last       (is_last),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .sorted_key    (sorted_key),
        .sorted_credit (sorted_credit),
        .arrival_index (arrival_index),
        .end_of_run    (end_of_run),
        .overflowed    (overflowed)
    );

    record_sort_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .course_key    (course_key),
        .credit_value  (credit_value),
        .is_last       (is_last),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .sorted_key    (sorted_key),
        .sorted_credit (sorted_credit),
        .arrival_index (arrival_index),
        .end_of_run    (end_of_run),
        .overflowed    (overflowed),
        .fail_count    (fail_count),
        .pending       (pending),
        .results_seen  (results_seen)
    );

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
            $display("tb failed");
            $finish;
        end
    end

    // receiver back-pressure, switching between randomly chosen modes
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = stall_mode_t'($urandom_range(0, 3));
            stall_left = $urandom_range(4, 40);
        end
        stall_left--;
        case (stall_mode)
            STALL_NONE:   out_stall <= 1'b0;
            STALL_RANDOM: out_stall <= 1'($urandom_range(0, 1));
            STALL_HEAVY:  out_stall <= ($urandom_range(0, 7) != 0);
            default:      out_stall <= ~out_stall;
        endcase
    end

    task automatic send_record(input logic [rsbk_pkg::KEY_W-1:0] key,
                               input logic [rsbk_pkg::CRED_W-1:0] credit,
                               input logic last);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
        end
        in_valid     <= 1'b1;
        course_key   <= key;
        credit_value <= credit;
        is_last      <= last;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        burst_left--;
        records_sent++;
        if (last)
            sets_sent++;
    endtask

    task automatic wait_drained();
        in_valid   <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic send_random_set(input int n);
        key_mix_t                   mix;
        logic [rsbk_pkg::KEY_W-1:0] key;
        mix = key_mix_t'($urandom_range(0, 3) % 3);
        if (n > rsbk_pkg::CAPACITY)
            overflow_sets++;
        for (int i = 0; i < n; i++)
        begin
            case (mix)
                MIX_TIES:  key = rsbk_pkg::KEY_W'($urandom_range(0, 3));
                MIX_EDGES: case ($urandom_range(0, 3))
                               0:       key = '0;
                               1:       key = '1;
                               2:       key = {1'b1, {(rsbk_pkg::KEY_W-1){1'b0}}};
                               default: key = {1'b0, {(rsbk_pkg::KEY_W-1){1'b1}}};
                           endcase
                default:   key = rsbk_pkg::KEY_W'($urandom);
            endcase
            send_record(key, rsbk_pkg::CRED_W'($urandom), i == n - 1);
        end
    endtask

    initial
    begin
        int  n;
        int  pick;
        bit  mid_drain_done;
        mid_drain_done = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single-record sets at both key extremes
        send_record('1, '1, 1'b1);
        send_record('0, '0, 1'b1);
        // equal keys come out in arrival order
        send_record(16'd5, 4'd1, 1'b0);
        send_record(16'd5, 4'd2, 1'b0);
        send_record(16'd3, 4'd3, 1'b0);
        send_record(16'd5, 4'd4, 1'b0);
        send_record(16'd3, 4'd5, 1'b1);
        // full set in descending order, then a last record that gets dropped
        for (int i = 0; i < rsbk_pkg::CAPACITY; i++)
            send_record(rsbk_pkg::KEY_W'(15 - i) * 16'h1111, rsbk_pkg::CRED_W'(i), 1'b0);
        send_record(16'h8000, 4'hA, 1'b1);
        overflow_sets++;
        wait_drained();

        while (records_sent < TOTAL_RECORDS)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 6)
                n = $urandom_range(1, 6);
            else if (pick < 8)
                n = $urandom_range(7, 15);
            else if (pick == 8)
                n = rsbk_pkg::CAPACITY;
            else
                n = $urandom_range(rsbk_pkg::CAPACITY + 1, rsbk_pkg::CAPACITY + 6);
            send_random_set(n);
            if (!mid_drain_done && records_sent > TOTAL_RECORDS / 2)
            begin
                wait_drained();
                mid_drain_done = 1'b1;
            end
            else if ($urandom_range(0, 7) == 0)
            begin
                wait_drained();
            end
        end

        wait_drained();
        repeat (40) @(posedge clk);

        $display("covered %0d sets, %0d records, %0d overflowing sets;", sets_sent,
                 records_sent, overflow_sets);
        $display("checked %0d sorted results against the predicted order", results_seen);
        if (fail_count == 0)
        begin
            $display("tb passed");
        end
        else
        begin
            $display("%0d mismatches", fail_count);
            $display("tb failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/rsbk_pkg.sv
rtl/rsbk_front.sv
rtl/rsbk_queue.sv
rtl/rsbk_back.sv
rtl/record_sort_by_key_unit.sv
dv/record_sort_checker.sv
dv/tb.sv
